// ===== rtl/mta_pkg.sv =====
// ----------------------------------------------------------------------------
// mta_pkg
// Shared types and constants for the motion-to-arrow tap unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mta_pkg;

  localparam int MTA_MAX_TAPS = 4;

  localparam int ACC_W   = 32;
  localparam int DELTA_W = 16;
  localparam int THR_W   = 15;
  localparam int IDLE_W  = 10;
  localparam int CMD_W   = 2;
  localparam int DIR_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int PROD_W  = ACC_W + THR_W;

  localparam logic [THR_W-1:0]  THR_RST  = THR_W'(16);
  localparam logic [IDLE_W-1:0] IDLE_LIMIT_RST = IDLE_W'(150);
  localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_X_MOVE = 2'd1,
    CMD_Y_MOVE = 2'd2,
    CMD_NONE   = 2'd3
  } mta_cmd_code_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } mta_dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_THR      = 2'd0,
    REG_Y_THR      = 2'd1,
    REG_IDLE_LIMIT = 2'd2,
    REG_UNUSED     = 2'd3
  } mta_reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_CHECK
  } mta_state_t;

  typedef struct packed {
    logic eval;
    logic step;
  } mta_ctl_t;

  typedef struct packed {
    logic x_ready;
    logic y_ready;
  } mta_stat_t;

  typedef struct packed {
    logic emit;
    logic tap_valid;
    logic last;
  } mta_emit_t;

endpackage

`default_nettype wire

// ===== rtl/motion_to_arrow_tap_unit.sv =====
// ----------------------------------------------------------------------------
// motion_to_arrow_tap_unit
// Turns relative X/Y pointer motion into left/right/up/down tap beats.
// ----------------------------------------------------------------------------
//   channel  dir  handshake           payload
//   in_      in   in_valid/in_stall   in_command, in_motion_delta
//   out_     out  out_valid/out_stall out_tap_valid, out_tap_direction,
//                                     out_last_of_run
//   cfg_     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// A tick or unused command is taken without stalling the input. A motion
// beat with n taps (n <= MAX_TAPS) stalls the input until its run is done:
// each tap is an evaluate state (magnitudes and ratio products registered)
// and a decide state. Output stalls hold the sequencer in the decide state.
// Reset restores thresholds 16, idle limit 150, clears the accumulators.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module motion_to_arrow_tap_unit #(
  parameter int MAX_TAPS = mta_pkg::MTA_MAX_TAPS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [mta_pkg::CMD_W-1:0]           in_command,
  input  wire logic signed [mta_pkg::DELTA_W-1:0]  in_motion_delta,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     out_tap_valid,
  output logic [mta_pkg::DIR_W-1:0]                out_tap_direction,
  output logic                                     out_last_of_run,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [mta_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [mta_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import mta_pkg::*;

  logic [THR_W-1:0]  x_thr_r, y_thr_r;
  logic [IDLE_W-1:0] idle_lim_r;
  logic              out_valid_r, out_tv_r, out_last_r;
  logic [DIR_W-1:0]  out_dir_r;

  logic       accept, motion, busy, out_free;
  mta_ctl_t   ctl;
  mta_stat_t  stat;
  mta_emit_t  emit;
  logic [DIR_W-1:0] tap_dir;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign accept    = in_valid && !busy;
  assign motion    = (in_command == CMD_X_MOVE) || (in_command == CMD_Y_MOVE);
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_thr_r    <= THR_RST;
      y_thr_r    <= THR_RST;
      idle_lim_r <= IDLE_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_X_THR:      x_thr_r    <= cfg_data[THR_W-1:0];
        REG_Y_THR:      y_thr_r    <= cfg_data[THR_W-1:0];
        REG_IDLE_LIMIT: idle_lim_r <= cfg_data[IDLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.emit) begin
      out_tv_r   <= emit.tap_valid;
      out_dir_r  <= emit.tap_valid ? tap_dir : DIR_LEFT;
      out_last_r <= emit.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_tap_valid     = out_tv_r;
  assign out_tap_direction = out_dir_r;
  assign out_last_of_run   = out_last_r;

  mta_ctrl #(
    .MAX_TAPS(MAX_TAPS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .motion_accept (accept && motion),
    .out_free      (out_free),
    .stat          (stat),
    .ctl           (ctl),
    .emit          (emit),
    .busy          (busy)
  );

  mta_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .command    (in_command),
    .delta      (in_motion_delta),
    .x_thr      (x_thr_r),
    .y_thr      (y_thr_r),
    .idle_limit (idle_lim_r),
    .ctl        (ctl),
    .stat       (stat),
    .tap_dir    (tap_dir)
  );

endmodule

`default_nettype wire

// ===== rtl/mta_ctrl.sv =====
// ----------------------------------------------------------------------------
// mta_ctrl
// Sequencer: evaluates the accumulators, issues taps and emits result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mta_ctrl #(
  parameter int MAX_TAPS = mta_pkg::MTA_MAX_TAPS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             motion_accept,
  input  wire logic             out_free,
  input  mta_pkg::mta_stat_t    stat,
  output mta_pkg::mta_ctl_t     ctl,
  output mta_pkg::mta_emit_t    emit,
  output logic                  busy
);
  import mta_pkg::*;

  localparam int CNT_W = $clog2(MAX_TAPS + 1);

  mta_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pend_r, pend_nxt;
  logic             more;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  assign more = (stat.x_ready || stat.y_ready) && (count_r != CNT_W'(MAX_TAPS));

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    pend_nxt  = pend_r;
    ctl       = '0;
    emit      = '0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (motion_accept) begin
          state_nxt = ST_EVAL;
          count_nxt = '0;
          pend_nxt  = 1'b0;
        end
      end
      ST_EVAL: begin
        ctl.eval  = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (!more) begin
          if (out_free) begin
            emit.emit      = 1'b1;
            emit.tap_valid = pend_r;
            emit.last      = 1'b1;
            pend_nxt       = 1'b0;
            state_nxt      = ST_IDLE;
          end
        end else if (!pend_r || out_free) begin
          emit.emit      = pend_r;
          emit.tap_valid = 1'b1;
          emit.last      = 1'b0;
          ctl.step       = 1'b1;
          pend_nxt       = 1'b1;
          count_nxt      = count_r + CNT_W'(1);
          state_nxt      = ST_EVAL;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/mta_dp.sv =====
// ----------------------------------------------------------------------------
// mta_dp
// Datapath: axis accumulators, idle counter, readiness and ratio compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mta_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          accept,
  input  wire logic [mta_pkg::CMD_W-1:0]     command,
  input  wire logic signed [mta_pkg::DELTA_W-1:0] delta,
  input  wire logic [mta_pkg::THR_W-1:0]     x_thr,
  input  wire logic [mta_pkg::THR_W-1:0]     y_thr,
  input  wire logic [mta_pkg::IDLE_W-1:0]    idle_limit,
  input  mta_pkg::mta_ctl_t                  ctl,
  output mta_pkg::mta_stat_t                 stat,
  output logic [mta_pkg::DIR_W-1:0]          tap_dir
);
  import mta_pkg::*;

  logic signed [ACC_W-1:0] x_acc_r, x_acc_nxt;
  logic signed [ACC_W-1:0] y_acc_r, y_acc_nxt;
  logic [IDLE_W-1:0]       idle_r, idle_nxt;
  logic                    xr_r, yr_r;
  logic [PROD_W-1:0]       px_r, py_r;
  logic [DIR_W-1:0]        dir_r, dir_nxt;

  logic [THR_W-1:0]        xth, yth;
  logic [ACC_W-1:0]        ax, ay;
  logic signed [ACC_W-1:0] base, summed;
  logic signed [ACC_W:0]   sum;
  logic                    drop, use_x;

  assign xth = (x_thr == '0) ? THR_W'(1) : x_thr;
  assign yth = (y_thr == '0) ? THR_W'(1) : y_thr;

  assign ax = x_acc_r[ACC_W-1] ? ACC_W'(-x_acc_r) : ACC_W'(x_acc_r);
  assign ay = y_acc_r[ACC_W-1] ? ACC_W'(-y_acc_r) : ACC_W'(y_acc_r);

  assign drop = idle_r > idle_limit;
  assign base = drop ? '0 : ((command == CMD_X_MOVE) ? x_acc_r : y_acc_r);
  assign sum  = {base[ACC_W-1], base} + (ACC_W+1)'(delta);

  always_comb begin
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      summed = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      summed = sum[ACC_W-1:0];
    end
  end

  assign use_x = xr_r && (!yr_r || (px_r >= py_r));

  always_comb begin
    x_acc_nxt = x_acc_r;
    y_acc_nxt = y_acc_r;
    idle_nxt  = idle_r;
    dir_nxt   = dir_r;
    if (accept) begin
      case (command)
        CMD_TICK: begin
          if (idle_r != IDLE_MAX) begin
            idle_nxt = idle_r + IDLE_W'(1);
          end
        end
        CMD_X_MOVE: begin
          idle_nxt  = '0;
          x_acc_nxt = summed;
          if (drop) begin
            y_acc_nxt = '0;
          end
        end
        CMD_Y_MOVE: begin
          idle_nxt  = '0;
          y_acc_nxt = summed;
          if (drop) begin
            x_acc_nxt = '0;
          end
        end
        default: begin
        end
      endcase
    end else if (ctl.step) begin
      if (use_x) begin
        if (x_acc_r > 0) begin
          dir_nxt   = DIR_RIGHT;
          x_acc_nxt = x_acc_r - ACC_W'(xth);
        end else begin
          dir_nxt   = DIR_LEFT;
          x_acc_nxt = x_acc_r + ACC_W'(xth);
        end
      end else begin
        if (y_acc_r > 0) begin
          dir_nxt   = DIR_DOWN;
          y_acc_nxt = y_acc_r - ACC_W'(yth);
        end else begin
          dir_nxt   = DIR_UP;
          y_acc_nxt = y_acc_r + ACC_W'(yth);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_acc_r <= '0;
      y_acc_r <= '0;
      idle_r  <= IDLE_MAX;
      xr_r    <= 1'b0;
      yr_r    <= 1'b0;
    end else begin
      x_acc_r <= x_acc_nxt;
      y_acc_r <= y_acc_nxt;
      idle_r  <= idle_nxt;
      if (ctl.eval) begin
        xr_r <= ax >= ACC_W'(xth);
        yr_r <= ay >= ACC_W'(yth);
      end
    end
  end

  // ratio compare: |x|/xth >= |y|/yth  <=>  |x|*yth >= |y|*xth
  always_ff @(posedge clk) begin
    dir_r <= dir_nxt;
    if (ctl.eval) begin
      px_r <= PROD_W'(ax) * PROD_W'(yth);
      py_r <= PROD_W'(ay) * PROD_W'(xth);
    end
  end

  assign stat.x_ready = xr_r;
  assign stat.y_ready = yr_r;
  assign tap_dir      = dir_r;

endmodule

`default_nettype wire

// ===== dv/tb_motion_to_arrow_tap_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_motion_to_arrow_tap_unit
// Self-checking bench for the motion-to-arrow tap unit. A tap predictor runs
// alongside the block and queues the expected tap beats for every accepted
// motion beat; a monitor pops and compares them field by field. Stimulus is a
// short directed pass, idle-limit and large-travel sweeps, then random phases
// under several register settings with bursty input and output back-pressure.
// ----------------------------------------------------------------------------
module tb_motion_to_arrow_tap_unit;
  import mta_pkg::*;

  localparam int     SETTLE_CYCLES   = 24;
  localparam longint CYCLE_LIMIT     = 4_000_000;
  localparam int     SAT_DOWN_BEATS  = 40;
  localparam int     SAT_UP_BEATS    = 9;
  localparam int     IDLE_TEST_LIMIT = 24;
  localparam int     RANDOM_PHASES   = 6;
  localparam int     PHASE_BEATS     = 40;
  localparam longint ACC_MAX         = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_MIN         = -(longint'(1) <<< (ACC_W - 1));

  typedef enum int {STALL_OFF, STALL_RANDOM, STALL_PATTERN} stall_mode_t;

  typedef struct packed {
    logic     tap_valid;
    mta_dir_t direction;
    logic     last;
  } tap_beat_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [CMD_W-1:0]          in_command = CMD_TICK;
  logic signed [DELTA_W-1:0] in_motion_delta = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_tap_valid;
  logic [DIR_W-1:0]          out_tap_direction;
  logic                      out_last_of_run;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = REG_X_THR;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  // predictor state
  logic signed [ACC_W-1:0] x_acc = '0;
  logic signed [ACC_W-1:0] y_acc = '0;
  logic [IDLE_W-1:0]       idle_cnt = IDLE_MAX;
  logic [THR_W-1:0]        x_thr = THR_RST;
  logic [THR_W-1:0]        y_thr = THR_RST;
  logic [IDLE_W-1:0]       idle_lim = IDLE_LIMIT_RST;

  tap_beat_t   expected_taps[$];
  int          mismatches = 0;
  longint      cycle_cnt = 0;
  stall_mode_t stall_mode = STALL_OFF;
  logic [7:0]  stall_pattern = '0;
  bit          gaps_on = 1'b0;
  bit          holding = 1'b0;
  int          burst_left = 0;

  motion_to_arrow_tap_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_motion_delta   (in_motion_delta),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_tap_valid     (out_tap_valid),
    .out_tap_direction (out_tap_direction),
    .out_last_of_run   (out_last_of_run),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint eff_thr(input logic [THR_W-1:0] thr);
    return (thr == '0) ? longint'(1) : longint'(thr);
  endfunction

  function automatic void predict_taps(input mta_cmd_code_t cmd,
                                       input logic signed [DELTA_W-1:0] delta);
    longint    sum, ax, ay, xth, yth;
    bit        x_ready, y_ready, take_x, have_beat;
    int        k;
    tap_beat_t beat;
    if (cmd == CMD_TICK) begin
      if (idle_cnt != IDLE_MAX) idle_cnt = idle_cnt + 1'b1;
      return;
    end
    if (cmd == CMD_NONE) return;
    if (idle_cnt > idle_lim) begin
      x_acc = '0;
      y_acc = '0;
    end
    idle_cnt = '0;
    sum = longint'(cmd == CMD_X_MOVE ? x_acc : y_acc) + longint'(delta);
    if (sum > ACC_MAX) sum = ACC_MAX;
    if (sum < ACC_MIN) sum = ACC_MIN;
    if (cmd == CMD_X_MOVE) x_acc = ACC_W'(sum);
    else y_acc = ACC_W'(sum);
    xth = eff_thr(x_thr);
    yth = eff_thr(y_thr);
    have_beat = 1'b0;
    beat = '0;
    for (k = 0; k < MTA_MAX_TAPS; k++) begin
      ax = (x_acc < 0) ? -longint'(x_acc) : longint'(x_acc);
      ay = (y_acc < 0) ? -longint'(y_acc) : longint'(y_acc);
      x_ready = (ax >= xth);
      y_ready = (ay >= yth);
      if (!x_ready && !y_ready) break;
      // ties on covered fraction go to X
      take_x = x_ready && (!y_ready || ax * yth >= ay * xth);
      if (have_beat) expected_taps.push_back(beat);
      beat.tap_valid = 1'b1;
      beat.last = 1'b0;
      if (take_x) begin
        beat.direction = (x_acc > 0) ? DIR_RIGHT : DIR_LEFT;
        x_acc = ACC_W'((x_acc > 0) ? longint'(x_acc) - xth : longint'(x_acc) + xth);
      end else begin
        beat.direction = (y_acc > 0) ? DIR_DOWN : DIR_UP;
        y_acc = ACC_W'((y_acc > 0) ? longint'(y_acc) - yth : longint'(y_acc) + yth);
      end
      have_beat = 1'b1;
    end
    if (!have_beat) begin
      beat.tap_valid = 1'b0;
      beat.direction = DIR_LEFT;
    end
    beat.last = 1'b1;
    expected_taps.push_back(beat);
  endfunction

  function automatic void report_mismatch(input string msg);
    if (mismatches < 10) $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endfunction

  always @(posedge clk) begin
    tap_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_taps.size() == 0) begin
        report_mismatch($sformatf("unexpected beat tap_valid=%0b dir=%0d last=%0b",
                                  out_tap_valid, out_tap_direction, out_last_of_run));
      end else begin
        want = expected_taps.pop_front();
        if (out_tap_valid !== want.tap_valid)
          report_mismatch($sformatf("tap_valid exp %0b got %0b",
                                    want.tap_valid, out_tap_valid));
        if (out_tap_direction !== want.direction)
          report_mismatch($sformatf("tap_direction exp %0d got %0d",
                                    want.direction, out_tap_direction));
        if (out_last_of_run !== want.last)
          report_mismatch($sformatf("last_of_run exp %0b got %0b",
                                    want.last, out_last_of_run));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt[5:0] == 6'd0) stall_pattern <= 8'($urandom);
    case (stall_mode)
      STALL_RANDOM:  out_stall <= ($urandom_range(0, 99) < 30);
      STALL_PATTERN: out_stall <= stall_pattern[cycle_cnt[2:0]];
      default:       out_stall <= 1'b0;
    endcase
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_beat(input mta_cmd_code_t cmd, input logic signed [DELTA_W-1:0] delta);
    int gap;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_motion_delta <= delta;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_taps(cmd, delta);
    holding = 1'b1;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        holding = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop sending and wait for every queued tap beat
  task automatic drain_taps(input int settle);
    if (holding) begin
      in_valid <= 1'b0;
      holding = 1'b0;
    end
    do @(posedge clk); while (expected_taps.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input mta_reg_idx_t idx, input logic [CFG_DATA_W-1:0] data,
                           input bit release_bus);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (release_bus) cfg_valid <= 1'b0;
    case (idx)
      REG_X_THR:      x_thr = data[THR_W-1:0];
      REG_Y_THR:      y_thr = data[THR_W-1:0];
      REG_IDLE_LIMIT: idle_lim = data[IDLE_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_threshold();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return CFG_DATA_W'(1);
      2:       return '1;
      3:       return CFG_DATA_W'($urandom_range(2, 40));
      default: return CFG_DATA_W'($urandom_range(1, 32767));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_idle_limit();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return CFG_DATA_W'($urandom_range(1, 4));
      2:       return CFG_DATA_W'($urandom_range(5, 30));
      default: return CFG_DATA_W'(IDLE_MAX);
    endcase
  endfunction

  task automatic test_directed();
    stall_mode = STALL_RANDOM;
    gaps_on = 1'b1;
    // reset register values
    send_beat(CMD_X_MOVE, 16'sd15);
    send_beat(CMD_X_MOVE, 16'sd1);
    send_beat(CMD_Y_MOVE, -16'sd16);
    send_beat(CMD_X_MOVE, 16'sd0);
    send_beat(CMD_NONE, 16'h5555);
    send_beat(CMD_TICK, 16'haaaa);
    send_beat(CMD_X_MOVE, 16'sh7fff);
    send_beat(CMD_Y_MOVE, 16'sh8000);
    send_beat(CMD_Y_MOVE, 16'sd0);
    // equal thresholds, tie between axes, drop after a single tick
    drain_taps(SETTLE_CYCLES);
    write_reg(REG_X_THR, 15'd4096, 1'b0);
    write_reg(REG_Y_THR, 15'd4096, 1'b0);
    write_reg(REG_IDLE_LIMIT, 15'd0, 1'b1);
    send_beat(CMD_TICK, 16'h0000);
    send_beat(CMD_X_MOVE, 16'sh7fff);
    send_beat(CMD_Y_MOVE, 16'sd16383);
    send_beat(CMD_X_MOVE, -16'sd1);
    send_beat(CMD_TICK, 16'hffff);
    send_beat(CMD_Y_MOVE, 16'sd5);
    // zero threshold acts as one, largest threshold, no drop at 1023
    drain_taps(SETTLE_CYCLES);
    write_reg(REG_X_THR, 15'd0, 1'b0);
    write_reg(REG_Y_THR, 15'h7fff, 1'b0);
    write_reg(REG_IDLE_LIMIT, {5'b10101, IDLE_MAX}, 1'b0);
    write_reg(REG_UNUSED, 15'h7fff, 1'b1);
    send_beat(CMD_X_MOVE, -16'sd1);
    send_beat(CMD_X_MOVE, 16'sd1);
    send_beat(CMD_Y_MOVE, 16'sh7fff);
    send_beat(CMD_Y_MOVE, -16'sd32767);
    send_beat(CMD_Y_MOVE, -16'sd32766);
    send_beat(CMD_TICK, 16'h0001);
    send_beat(CMD_Y_MOVE, 16'sd0);
  endtask

  // idle count right at the limit keeps travel, one more tick drops it
  task automatic test_idle_limit();
    drain_taps(SETTLE_CYCLES);
    write_reg(REG_X_THR, 15'd16, 1'b0);
    write_reg(REG_Y_THR, 15'd16, 1'b0);
    write_reg(REG_IDLE_LIMIT, CFG_DATA_W'(IDLE_TEST_LIMIT), 1'b1);
    send_beat(CMD_X_MOVE, 16'sd10);
    repeat (IDLE_TEST_LIMIT) send_beat(CMD_TICK, 16'($urandom));
    send_beat(CMD_X_MOVE, 16'sd6);
    send_beat(CMD_X_MOVE, 16'sd10);
    repeat (IDLE_TEST_LIMIT + 1) send_beat(CMD_TICK, 16'($urandom));
    send_beat(CMD_X_MOVE, 16'sd6);
  endtask

  // drive X far negative, then walk it back past zero
  task automatic test_saturation();
    drain_taps(SETTLE_CYCLES);
    stall_mode = STALL_OFF;
    gaps_on = 1'b0;
    write_reg(REG_X_THR, 15'd0, 1'b0);
    write_reg(REG_IDLE_LIMIT, CFG_DATA_W'(IDLE_MAX), 1'b1);
    repeat (SAT_DOWN_BEATS) send_beat(CMD_X_MOVE, 16'sh8000);
    drain_taps(SETTLE_CYCLES);
    write_reg(REG_X_THR, 15'h7fff, 1'b1);
    repeat (SAT_UP_BEATS) send_beat(CMD_X_MOVE, 16'sh7fff);
    send_beat(CMD_X_MOVE, 16'($urandom_range(0, 255)));
    send_beat(CMD_X_MOVE, -16'sd1);
    stall_mode = STALL_RANDOM;
    gaps_on = 1'b1;
  endtask

  task automatic test_random();
    int            phase, i, roll, span, run;
    mta_cmd_code_t cmd;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_taps(SETTLE_CYCLES);
      write_reg(REG_X_THR, pick_threshold(), 1'b0);
      write_reg(REG_Y_THR, pick_threshold(), 1'b0);
      write_reg(REG_IDLE_LIMIT, pick_idle_limit(), 1'b1);
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      gaps_on = ($urandom_range(0, 3) != 0);
      for (i = 0; i < PHASE_BEATS; i++) begin
        roll = $urandom_range(0, 99);
        cmd = $urandom_range(0, 1) ? CMD_X_MOVE : CMD_Y_MOVE;
        if (roll < 62) begin
          // motion sized around the axis threshold
          span = int'(3 * eff_thr(cmd == CMD_X_MOVE ? x_thr : y_thr));
          if (span > 32767) span = 32767;
          send_beat(cmd, DELTA_W'(longint'($urandom_range(0, 2 * span)) - span));
        end else if (roll < 72) begin
          send_beat(cmd, DELTA_W'($urandom));
        end else if (roll < 88) begin
          run = (idle_lim <= 40) ? $urandom_range(0, idle_lim + 2) : $urandom_range(1, 6);
          repeat (run) send_beat(CMD_TICK, DELTA_W'($urandom));
        end else if (roll < 96) begin
          send_beat(CMD_NONE, DELTA_W'($urandom));
        end else begin
          drain_taps(0);
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_idle_limit();
    test_saturation();
    test_random();
    drain_taps(SETTLE_CYCLES);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mta_pkg.sv
rtl/mta_ctrl.sv
rtl/mta_dp.sv
rtl/motion_to_arrow_tap_unit.sv
dv/tb_motion_to_arrow_tap_unit.sv
